@@ design/teb_pkg.sv @@
// shared types and constants of the trigger-aligned event builder
// used by teb_ctrl, teb_dp and the top level
`default_nettype none
package teb_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int QUEUE_DEPTH  = 16;
  localparam int HANDLE_BITS  = 16;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int POS_W        = $clog2(QUEUE_DEPTH);
  localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W       = CH_W + POS_W;
  localparam int TRIG_W       = 32;
  localparam int CNT_W        = 4;
  localparam int MODE_W       = 2;
  localparam int SLOT_W       = TRIG_W + HANDLE_BITS;
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 56;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [MODE_W-1:0] MODE_RECEIVE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONNECT    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISCONNECT = 2'd2;

  localparam logic [0:0] REG_MIN_SUB = 1'b0;

  typedef struct packed {
    logic            capture;
    logic            set_member;
    logic            push;
    logic            do_connect;
    logic            do_disconnect;
    logic            load_ovf;
    logic            scan_clear;
    logic            rd;
    logic            eval;
    logic            pop;
    logic            emit;
    logic            cleanup;
    logic [CH_W-1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              any_empty;
    logic              match;
    logic              emit_ok;
    logic              out_free;
  } status_t;

endpackage
`default_nettype wire

@@ design/teb_dp.sv @@
// datapath: channel fifos in one memory, masks, scan registers, output register
// depends on teb_pkg
`default_nettype none
module teb_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  teb_pkg::cmd_t                cmd,
  output teb_pkg::status_t                   sts,
  input  wire  [teb_pkg::MODE_W-1:0]         in_mode,
  input  wire  [teb_pkg::CH_W-1:0]           in_chan,
  input  wire  [teb_pkg::TRIG_W-1:0]         in_trig,
  input  wire  [teb_pkg::HANDLE_BITS-1:0]    in_hand,
  input  wire                                cfg_we,
  input  wire  [teb_pkg::CNT_W-1:0]          cfg_wdata,
  output logic [teb_pkg::CNT_W-1:0]          min_sub,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               out_ovf,
  output logic [teb_pkg::TRIG_W-1:0]         out_trig,
  output logic [teb_pkg::CH_W-1:0]           out_chan,
  output logic [teb_pkg::HANDLE_BITS-1:0]    out_hand,
  output logic [teb_pkg::CNT_W-1:0]          out_count,
  output logic                               out_last
);

  logic [teb_pkg::SLOT_W-1:0]      mem [teb_pkg::NUM_CHANNELS*teb_pkg::QUEUE_DEPTH];
  logic [teb_pkg::SLOT_W-1:0]      rdata_r;
  logic [teb_pkg::POS_W-1:0]       head_r [teb_pkg::NUM_CHANNELS];
  logic [teb_pkg::FILL_W-1:0]      fill_r [teb_pkg::NUM_CHANNELS];
  logic [teb_pkg::NUM_CHANNELS-1:0] member_r, inactive_r;
  logic [teb_pkg::MODE_W-1:0]      mode_r;
  logic [teb_pkg::CH_W-1:0]        ich_r;
  logic [teb_pkg::TRIG_W-1:0]      trig_r, min_r;
  logic [teb_pkg::HANDLE_BITS-1:0] hand_r;
  logic [teb_pkg::CNT_W-1:0]       min_sub_r, count_r, emitted_r;
  logic                            out_valid_r, ovf_r, last_r;
  logic [teb_pkg::TRIG_W-1:0]      otrig_r;
  logic [teb_pkg::CH_W-1:0]        ochan_r;
  logic [teb_pkg::HANDLE_BITS-1:0] ohand_r;
  logic [teb_pkg::CNT_W-1:0]       ocount_r;

  logic [teb_pkg::FILL_W-1:0]      wsum;
  logic [teb_pkg::POS_W-1:0]       wpos;
  logic [teb_pkg::TRIG_W-1:0]      rd_trig;
  logic [teb_pkg::HANDLE_BITS-1:0] rd_hand;
  logic [teb_pkg::NUM_CHANNELS-1:0] bit_i, empty_v, inact_nxt;
  logic                            load_any;

  assign bit_i   = teb_pkg::NUM_CHANNELS'(1) << ich_r;
  assign wsum    = teb_pkg::FILL_W'(head_r[ich_r]) + fill_r[ich_r];
  assign wpos    = (wsum >= teb_pkg::FILL_W'(teb_pkg::QUEUE_DEPTH))
                   ? teb_pkg::POS_W'(wsum - teb_pkg::FILL_W'(teb_pkg::QUEUE_DEPTH))
                   : teb_pkg::POS_W'(wsum);
  assign rd_trig = rdata_r[teb_pkg::SLOT_W-1 -: teb_pkg::TRIG_W];
  assign rd_hand = rdata_r[teb_pkg::HANDLE_BITS-1:0];
  assign inact_nxt = inactive_r | bit_i;
  assign load_any  = cmd.load_ovf | cmd.emit;

  always_comb begin
    for (int c = 0; c < teb_pkg::NUM_CHANNELS; c++) begin
      empty_v[c] = member_r[c] && (fill_r[c] == '0);
    end
  end

  assign sts.mode      = mode_r;
  assign sts.full      = fill_r[ich_r] == teb_pkg::FILL_W'(teb_pkg::QUEUE_DEPTH);
  assign sts.any_empty = |empty_v;
  assign sts.match     = member_r[cmd.chan] && (rd_trig == min_r);
  assign sts.emit_ok   = count_r >= min_sub_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // fifo memory
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[{ich_r, wpos}] <= {trig_r, hand_r};
    end
    if (cmd.rd) begin
      rdata_r <= mem[{cmd.chan, head_r[cmd.chan]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_r    <= '0;
      inactive_r  <= '0;
      min_sub_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < teb_pkg::NUM_CHANNELS; c++) begin
        head_r[c] <= '0;
        fill_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        min_sub_r <= cfg_wdata;
      end
      if (cmd.set_member) begin
        member_r <= member_r | bit_i;
      end
      if (cmd.push) begin
        fill_r[ich_r] <= fill_r[ich_r] + teb_pkg::FILL_W'(1);
      end
      if (cmd.do_connect) begin
        member_r      <= member_r | bit_i;
        inactive_r    <= inactive_r & ~bit_i;
        head_r[ich_r] <= '0;
        fill_r[ich_r] <= '0;
      end
      if (cmd.do_disconnect) begin
        if (inact_nxt == member_r) begin
          member_r   <= '0;
          inactive_r <= '0;
          for (int c = 0; c < teb_pkg::NUM_CHANNELS; c++) begin
            head_r[c] <= '0;
            fill_r[c] <= '0;
          end
        end else begin
          inactive_r <= inact_nxt;
        end
      end
      if (cmd.pop) begin
        head_r[cmd.chan] <= (head_r[cmd.chan] == teb_pkg::POS_W'(teb_pkg::QUEUE_DEPTH - 1))
                            ? '0 : head_r[cmd.chan] + teb_pkg::POS_W'(1);
        fill_r[cmd.chan] <= fill_r[cmd.chan] - teb_pkg::FILL_W'(1);
      end
      if (cmd.cleanup) begin
        for (int c = 0; c < teb_pkg::NUM_CHANNELS; c++) begin
          if (inactive_r[c] && member_r[c] && fill_r[c] == '0) begin
            member_r[c]   <= 1'b0;
            inactive_r[c] <= 1'b0;
            head_r[c]     <= '0;
          end
        end
      end
      if (load_any) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item, scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      ich_r  <= in_chan;
      trig_r <= in_trig;
      hand_r <= in_hand;
    end
    if (cmd.scan_clear) begin
      min_r     <= '1;
      count_r   <= '0;
      emitted_r <= '0;
    end
    if (cmd.eval && member_r[cmd.chan]) begin
      if (rd_trig < min_r) begin
        min_r   <= rd_trig;
        count_r <= teb_pkg::CNT_W'(1);
      end else if (rd_trig == min_r) begin
        count_r <= count_r + teb_pkg::CNT_W'(1);
      end
    end
    if (cmd.load_ovf) begin
      ovf_r    <= 1'b1;
      otrig_r  <= trig_r;
      ochan_r  <= ich_r;
      ohand_r  <= hand_r;
      ocount_r <= '0;
      last_r   <= 1'b0;
    end
    if (cmd.emit) begin
      ovf_r     <= 1'b0;
      otrig_r   <= min_r;
      ochan_r   <= cmd.chan;
      ohand_r   <= rd_hand;
      ocount_r  <= count_r;
      last_r    <= (emitted_r + teb_pkg::CNT_W'(1)) == count_r;
      emitted_r <= emitted_r + teb_pkg::CNT_W'(1);
    end
  end

  assign min_sub   = min_sub_r;
  assign out_valid = out_valid_r;
  assign out_ovf   = ovf_r;
  assign out_trig  = otrig_r;
  assign out_chan  = ochan_r;
  assign out_hand  = ohand_r;
  assign out_count = ocount_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

@@ design/teb_ctrl.sv @@
// controller: decodes an item and sequences the two head scans
// depends on teb_pkg
`default_nettype none
module teb_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  teb_pkg::status_t sts,
  output teb_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_OVF, ST_CHECK, ST_RD1, ST_EV1, ST_RD2, ST_EV2, ST_CLEAN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [teb_pkg::CH_W-1:0]  chan_r, chan_nxt;
  logic                      last_chan;

  assign last_chan = chan_r == teb_pkg::CH_W'(teb_pkg::NUM_CHANNELS - 1);
  assign in_ready  = state_r == ST_IDLE;

  always_comb begin
    cmd       = '0;
    cmd.chan  = chan_r;
    state_nxt = state_r;
    chan_nxt  = chan_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (sts.mode)
          teb_pkg::MODE_RECEIVE: begin
            cmd.set_member = 1'b1;
            if (sts.full) begin
              state_nxt = ST_OVF;
            end else begin
              cmd.push  = 1'b1;
              state_nxt = ST_CHECK;
            end
          end
          teb_pkg::MODE_CONNECT:    cmd.do_connect = 1'b1;
          teb_pkg::MODE_DISCONNECT: cmd.do_disconnect = 1'b1;
          default: ;
        endcase
      end
      ST_OVF: begin
        if (sts.out_free) begin
          cmd.load_ovf = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (sts.any_empty) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_clear = 1'b1;
          chan_nxt       = '0;
          state_nxt      = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EV1;
      end
      ST_EV1: begin
        cmd.eval  = 1'b1;
        chan_nxt  = last_chan ? '0 : chan_r + teb_pkg::CH_W'(1);
        state_nxt = last_chan ? ST_RD2 : ST_RD1;
      end
      ST_RD2: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EV2;
      end
      ST_EV2: begin
        if (!(sts.match && sts.emit_ok && !sts.out_free)) begin
          cmd.pop   = sts.match;
          cmd.emit  = sts.match && sts.emit_ok;
          chan_nxt  = last_chan ? '0 : chan_r + teb_pkg::CH_W'(1);
          state_nxt = last_chan ? ST_CLEAN : ST_RD2;
        end
      end
      ST_CLEAN: begin
        cmd.cleanup = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/trigger_aligned_event_builder.sv @@
// top level of the trigger-aligned event builder
// depends on teb_pkg, teb_ctrl, teb_dp
//
// in_*: one word per item; in_tuser is the mode (receive, connect, disconnect),
// in_tdata carries channel, trigger number and event handle.
// out_*: one word per result; out_tuser flags an overflow, out_tlast marks the
// last sub-event of an assembled event.
// cfg_*: register 0 at byte address 0 holds the minimum sub-event count.
// connect, disconnect and ignored modes go through the decode state back to idle.
// a receive that overflows waits in the overflow state through any output stall;
// a receive that leaves a member fifo empty returns to idle after the check; one
// that assembles an event makes two passes over the 8 channel heads, each head
// read, then evaluated, via the registered fifo read port; then a cleanup step.
// one item is worked on at a time; in_tready is high only when idle.
// the result sits in an output register; a stalled receiver holds the
// second pass on the sub-event waiting to go out.
// reset empties all fifos, clears both masks and the register, and drops
// any pending result.
`default_nettype none
module trigger_aligned_event_builder (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [teb_pkg::IN_DATA_W-1:0]       in_tdata,  // channel, trigger_number, event_handle
  input  wire  [teb_pkg::MODE_W-1:0]          in_tuser,  // mode
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [teb_pkg::OUT_DATA_W-1:0]      out_tdata, // built_trigger, source_channel,
                                                         // sub_handle, sub_count
  output logic                                out_tuser, // overflow
  output logic                                out_tlast,
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire  [teb_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire  [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  teb_pkg::cmd_t                   cmd;
  teb_pkg::status_t                sts;
  logic                            cfg_we;
  logic [teb_pkg::CNT_W-1:0]       min_sub;
  logic [teb_pkg::TRIG_W-1:0]      o_trig;
  logic [teb_pkg::CH_W-1:0]        o_chan;
  logic [teb_pkg::HANDLE_BITS-1:0] o_hand;
  logic [teb_pkg::CNT_W-1:0]       o_count;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == teb_pkg::REG_MIN_SUB);
  assign cfg_prdata = (cfg_paddr[2] == teb_pkg::REG_MIN_SUB)
                      ? {28'd0, min_sub} : 32'd0;

  teb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  teb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_mode   (in_tuser),
    .in_chan   (in_tdata[2:0]),
    .in_trig   (in_tdata[34:3]),
    .in_hand   (in_tdata[50:35]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_pwdata[3:0]),
    .min_sub   (min_sub),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ovf   (out_tuser),
    .out_trig  (o_trig),
    .out_chan  (o_chan),
    .out_hand  (o_hand),
    .out_count (o_count),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, o_count, o_hand, o_chan, o_trig};

endmodule
`default_nettype wire

@@ design/teb_checker.sv @@
// port-level checks of the trigger-aligned event builder, bound to the top level
// depends on trigger_aligned_event_builder
`default_nettype none
module teb_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [55:0] out_tdata,
  input wire        out_tuser,
  input wire        out_tlast
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast && out_tdata[54:51] == 4'd0)
    else $error("overflow word with count or last");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[54:51] != 4'd0)
    else $error("sub-event word with zero count");

endmodule

bind trigger_aligned_event_builder teb_checker u_teb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

@@ tb/sv/tb_trigger_aligned_event_builder.sv @@
// self-checking testbench for trigger_aligned_event_builder
// drives items and register writes, predicts sub-event and overflow words, checks them in order
// depends on teb_pkg and the design files
`default_nettype none
module tb_trigger_aligned_event_builder;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  chan;
    logic [31:0] trig;
    logic [15:0] hnd;
  } item_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] trig;
    logic [2:0]  chan;
    logic [15:0] hnd;
    logic [3:0]  cnt;
    logic        last;
  } word_t;

  localparam int WATCHDOG = 20000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [teb_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [teb_pkg::MODE_W-1:0] in_tuser = '0;
  logic out_tvalid, out_tuser, out_tlast, in_tready, cfg_pready;
  logic [teb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [31:0] cfg_prdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [teb_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;

  trigger_aligned_event_builder dut (.*);

  initial forever #1 clk = ~clk;

  // predictor state
  logic [31:0] q_trig [8][16];
  logic [15:0] q_hnd [8][16];
  int q_head [8], q_fill [8];
  logic [7:0] members, inactive;
  int min_sub;

  item_t pending[$];
  word_t expected_words[$];
  int errors = 0, idle_cycles = 0;
  int send_idle = 0, recv_idle = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic predict_item(input item_t it);
    logic [31:0] lo;
    int cnt, c, pos;
    int chs [8];
    logic [15:0] hs [8];
    logic [7:0] b;
    b = 8'd1 << it.chan;
    cnt = 0;
    if (it.mode == teb_pkg::MODE_CONNECT) begin
      members |= b; q_head[it.chan] = 0; q_fill[it.chan] = 0; inactive &= ~b;
    end else if (it.mode == teb_pkg::MODE_DISCONNECT) begin
      inactive |= b;
      if (inactive == members) begin
        inactive = 0; members = 0;
        for (c = 0; c < 8; c++) begin q_head[c] = 0; q_fill[c] = 0; end
      end
    end else if (it.mode == teb_pkg::MODE_RECEIVE) begin
      members |= b;
      if (q_fill[it.chan] >= 16) begin
        expected_words.insert(expected_words.size(),
                              word_t'{1'b1, it.trig, it.chan, it.hnd, 4'd0, 1'b0});
        return;
      end
      pos = (q_head[it.chan] + q_fill[it.chan]) % 16;
      q_trig[it.chan][pos] = it.trig; q_hnd[it.chan][pos] = it.hnd;
      q_fill[it.chan]++;
      lo = 32'hFFFF_FFFF;
      for (c = 0; c < 8; c++)
        if (members[c]) begin
          if (q_fill[c] == 0) return;
          if (q_trig[c][q_head[c]] < lo) lo = q_trig[c][q_head[c]];
        end
      for (c = 0; c < 8; c++)
        if (members[c] && q_trig[c][q_head[c]] == lo) begin
          chs[cnt] = c; hs[cnt] = q_hnd[c][q_head[c]]; cnt++;
          q_head[c] = (q_head[c] + 1) % 16; q_fill[c]--;
        end
      for (c = 0; c < 8; c++)
        if (inactive[c] && members[c] && q_fill[c] == 0) begin
          members[c] = 0; inactive[c] = 0; q_head[c] = 0; q_fill[c] = 0;
        end
      if (cnt < min_sub) return;
      for (c = 0; c < cnt; c++)
        expected_words.insert(expected_words.size(),
                              word_t'{1'b0, lo, chs[c][2:0], hs[c], cnt[3:0], c == cnt - 1});
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid)
          predict_item(item_t'({in_tuser, in_tdata[2:0], in_tdata[34:3], in_tdata[50:35]}));
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          item_t it;
          it = pending[0];
          pending.delete(0);
          in_tvalid <= 1;
          in_tuser <= it.mode;
          in_tdata <= {5'd0, it.hnd, it.trig, it.chan};
        end else in_tvalid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        word_t got, exp_w;
        got = '{out_tuser, out_tdata[31:0], out_tdata[34:32], out_tdata[50:35],
                out_tdata[54:51], out_tlast};
        if (expected_words.size() == 0) report("word with nothing expected");
        else begin
          exp_w = expected_words[0];
          expected_words.delete(0);
          if (got !== exp_w) report($sformatf("got %h expected %h", got, exp_w));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_min(input int v);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= 3'(teb_pkg::REG_MIN_SUB); cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    min_sub = v & 15;
  endtask

  task automatic add(input logic [1:0] m, input int c, input int t, input int h);
    pending.insert(pending.size(), item_t'{m, c[2:0], t[31:0], h[15:0]});
  endtask

  task automatic drain;
    wait (pending.size() == 0);
    @(posedge clk);
    while (in_tvalid || !in_tready || expected_words.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int nch);
    int k, c;
    logic [31:0] base;
    base = $urandom;
    for (c = 0; c < nch; c++) add(teb_pkg::MODE_CONNECT, c, 0, 0);
    for (k = 0; k < n; k++) begin
      int r;
      r = $urandom_range(99);
      if (r < 80) add(teb_pkg::MODE_RECEIVE, $urandom_range(nch - 1),
                      base + $urandom_range(6), $urandom);
      else if (r < 86) add(teb_pkg::MODE_RECEIVE, $urandom_range(7), $urandom, $urandom);
      else if (r < 92) add(teb_pkg::MODE_DISCONNECT, $urandom_range(7), $urandom, $urandom);
      else if (r < 97) add(teb_pkg::MODE_CONNECT, $urandom_range(7), $urandom, $urandom);
      else add(MODE_UNUSED, $urandom_range(7), $urandom, $urandom);
      if (k % 8 == 7) base += $urandom_range(3);
    end
    for (c = 0; c < 8; c++) add(teb_pkg::MODE_DISCONNECT, c, 0, 0);
  endtask

  initial begin
    int c;
    members = 0; inactive = 0; min_sub = 0;
    for (c = 0; c < 8; c++) begin q_head[c] = 0; q_fill[c] = 0; end
    repeat (3) @(posedge clk);
    rst_n <= 1;
    send_idle = 13; recv_idle = 77;
    // directed: full pair build, overflow, extremes, unused mode
    add(teb_pkg::MODE_CONNECT, 0, 0, 0); add(teb_pkg::MODE_CONNECT, 7, 0, 0);
    add(teb_pkg::MODE_RECEIVE, 0, 32'hFFFF_FFFF, 16'hFFFF);
    add(teb_pkg::MODE_RECEIVE, 7, 32'hFFFF_FFFF, 16'h0000);
    add(MODE_UNUSED, 3, 32'h5555_AAAA, 16'h1234);
    for (c = 0; c < 17; c++) add(teb_pkg::MODE_RECEIVE, 0, c, 16'hA5A5 ^ c);
    add(teb_pkg::MODE_DISCONNECT, 3, 0, 0);
    add(teb_pkg::MODE_DISCONNECT, 0, 0, 0); add(teb_pkg::MODE_DISCONNECT, 7, 0, 0);
    drain();
    write_min(8);
    random_phase(60, 8);
    drain();
    write_min(15);
    random_phase(30, 3);
    drain();
    send_idle = 77; recv_idle = 13;
    write_min(2);
    random_phase(120, 4);
    drain();
    send_idle = 0; recv_idle = 0;
    write_min(0);
    random_phase(90, 2);
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

@@ trigger_aligned_event_builder.f @@
design/teb_pkg.sv
design/teb_dp.sv
design/teb_ctrl.sv
design/trigger_aligned_event_builder.sv
design/teb_checker.sv
tb/sv/tb_trigger_aligned_event_builder.sv
